FILE: hdl/wpse_pkg.sv
// Shared types, constants and the tangent table of the WS2812 slot encoder.
package wpse_pkg;

  localparam int ChanW    = 8;
  localparam int WordW    = 3 * ChanW;
  localparam int DutyW    = 6;
  localparam int GapW     = 7;
  localparam int BrightW  = 6;
  localparam int TanW     = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;

  localparam int QueueDepth = 2;

  localparam logic [BrightW-1:0] BrightMax   = 6'd45;
  localparam logic [BrightW-1:0] BrightReset = 6'd40;
  localparam logic [DutyW-1:0]   DutyOneReset  = 6'd60;
  localparam logic [DutyW-1:0]   DutyZeroReset = 6'd30;
  localparam logic [GapW-1:0]    GapMin   = 7'd1;
  localparam logic [GapW-1:0]    GapMax   = 7'd64;
  localparam logic [GapW-1:0]    GapReset = 7'd50;
  localparam logic [GapW-1:0]    PixelSlots = 7'd24;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegBrightness = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDutyOne    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDutyZero   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegResetSlots = 3'd3;

  // One classified item waiting for the serializer
  typedef struct packed {
    logic             gap;   // frame end: emit latch gap
    logic [WordW-1:0] word;  // green, red, blue, MSB first
  } item_t;

  // Slot settings seen by the serializer
  typedef struct packed {
    logic [DutyW-1:0] duty_one;
    logic [DutyW-1:0] duty_zero;
    logic [GapW-1:0]  reset_slots;
  } cfg_t;

  // tan(b degrees) in Q1.16, rounded
  function automatic logic [TanW-1:0] tan_q16(input logic [BrightW-1:0] b);
    logic [TanW-1:0] t;
    case (b)
      6'd0:  t = 17'd0;     6'd1:  t = 17'd1144;  6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;  6'd4:  t = 17'd4583;  6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;  6'd7:  t = 17'd8047;  6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380; 6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
      6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
      6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
      6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
      6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
      6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
      6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
      6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
      6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
      6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
      6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
      6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
      6'd45: t = 17'd65536;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/wpse_front.sv
// Intake: accepts items, scales pixel channels and packs the GRB word.
module wpse_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wpse_pkg::WordW-1:0]       s_tdata,
  input  logic                             s_tuser,
  input  logic [wpse_pkg::BrightW-1:0]     brightness,
  input  logic                             q_full,
  output logic                             q_push,
  output wpse_pkg::item_t                  q_item
);

  localparam int ProdW = wpse_pkg::ChanW + wpse_pkg::TanW;

  logic [wpse_pkg::TanW-1:0]  factor;
  logic [wpse_pkg::ChanW-1:0] red, green, blue;
  logic [ProdW-1:0]           prod_r, prod_g, prod_b;

  // Take an item whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  assign red    = s_tdata[7:0];
  assign green  = s_tdata[15:8];
  assign blue   = s_tdata[23:16];
  assign factor = wpse_pkg::tan_q16(brightness);

  // Scale each channel by the Q1.16 factor and truncate
  assign prod_r = {{wpse_pkg::TanW{1'b0}}, red}   * {{wpse_pkg::ChanW{1'b0}}, factor};
  assign prod_g = {{wpse_pkg::TanW{1'b0}}, green} * {{wpse_pkg::ChanW{1'b0}}, factor};
  assign prod_b = {{wpse_pkg::TanW{1'b0}}, blue}  * {{wpse_pkg::ChanW{1'b0}}, factor};

  // Pack green, red, blue; the queue entry registers the products
  always_comb begin
    q_item.gap  = s_tuser;
    q_item.word = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
  end

endmodule

FILE: hdl/wpse_queue.sv
// Short item queue between intake and serializer.
module wpse_queue #(
  parameter int Depth = wpse_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wpse_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output wpse_pkg::item_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  wpse_pkg::item_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/wpse_back.sv
// Serializer: turns queued items into one duty slot per cycle while the output is not stalled.
module wpse_back (
  input  logic                        clk,
  input  logic                        rst,
  input  wpse_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  wpse_pkg::item_t             q_head,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast
);

  logic                        busy, busy_next;
  logic                        gap;
  logic [wpse_pkg::WordW-1:0]  word, word_next;
  logic [wpse_pkg::GapW-1:0]   cnt, cnt_next;
  logic [wpse_pkg::DutyW-1:0]  duty, duty_next;
  logic                        cur_gap;
  logic                        out_free, emit;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = out_free && !busy && q_valid;
  assign emit     = out_free && (busy || q_valid);

  // Pick the running item, or start the head item in the same cycle
  always_comb begin
    if (busy) begin
      cur_gap   = gap;
      word_next = word;
      cnt_next  = cnt;
    end else begin
      cur_gap   = q_head.gap;
      word_next = q_head.word;
      cnt_next  = q_head.gap ? cfg.reset_slots : wpse_pkg::PixelSlots;
    end
    if (cur_gap) begin
      duty_next = '0;
    end else begin
      duty_next = word_next[wpse_pkg::WordW-1] ? cfg.duty_one : cfg.duty_zero;
    end
    busy_next = (cnt_next != wpse_pkg::GapW'(1));
  end

  // Advance one slot per output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        busy     <= busy_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold slot payload and remaining work
  always_ff @(posedge clk) begin
    if (emit) begin
      gap     <= cur_gap;
      word    <= {word_next[wpse_pkg::WordW-2:0], 1'b0};
      cnt     <= cnt_next - 1'b1;
      duty    <= duty_next;
      m_tlast <= !busy_next;
    end
  end

  assign m_tdata = {2'b00, duty};

endmodule

FILE: hdl/ws2812_pwm_slot_encoder.sv
// Top level of the WS2812 PWM slot encoder: configuration registers and wiring.
// Each pixel item (tuser low) is scaled by tan(brightness) and sent as 24 duty
// slots, green first, MSB first; a frame-end item (tuser high) sends reset_slots
// slots of duty 0. The serializer emits one slot per cycle while the output is not
// stalled, with no gap between items; the intake accepts items at once while the
// queue of QUEUE_DEPTH items has room. The first slot of an item is presented at
// the edge that takes it from the queue, so an item reaching an idle serializer
// passes the queue entry and then the output register before its first slot
// shows. m_tlast marks the final slot of each item.
// Configuration writes are always taken and belong to idle periods.
module ws2812_pwm_slot_encoder #(
  parameter int QUEUE_DEPTH = wpse_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                          s_tuser,   // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // duty[5:0], zero[7:6]
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wpse_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wpse_pkg::CfgDataW-1:0] cfg_data
);

  logic [wpse_pkg::BrightW-1:0] brightness;
  wpse_pkg::cfg_t               cfg;
  logic                         cfg_we;
  logic [wpse_pkg::GapW-1:0]    gap_req;
  logic                         q_push, q_pop, q_full, q_valid;
  wpse_pkg::item_t              q_item, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign gap_req   = cfg_data;

  // Write configuration registers; brightness and latch gap saturate to their ranges, duties keep the low six bits
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= wpse_pkg::BrightReset;
      cfg.duty_one    <= wpse_pkg::DutyOneReset;
      cfg.duty_zero   <= wpse_pkg::DutyZeroReset;
      cfg.reset_slots <= wpse_pkg::GapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        wpse_pkg::RegBrightness: begin
          brightness <= (cfg_data[5:0] > wpse_pkg::BrightMax) ?
                        wpse_pkg::BrightMax : cfg_data[5:0];
        end
        wpse_pkg::RegDutyOne:  cfg.duty_one  <= cfg_data[5:0];
        wpse_pkg::RegDutyZero: cfg.duty_zero <= cfg_data[5:0];
        wpse_pkg::RegResetSlots: begin
          if (gap_req < wpse_pkg::GapMin) begin
            cfg.reset_slots <= wpse_pkg::GapMin;
          end else if (gap_req > wpse_pkg::GapMax) begin
            cfg.reset_slots <= wpse_pkg::GapMax;
          end else begin
            cfg.reset_slots <= gap_req;
          end
        end
        default: ;
      endcase
    end
  end

  wpse_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .brightness (brightness),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  wpse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  wpse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: hdl/wpse_checker.sv
// Port-level checks of the slot encoder and their binding to the top level.
module wpse_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Hold a stalled slot
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled slot changed");

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Full queue implies the serializer is presenting a slot
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("intake stalled while output idle");

  // Keep padding bits of the duty byte clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:6] == 2'b00)
    else $error("duty padding nonzero");

endmodule

bind ws2812_pwm_slot_encoder wpse_checker u_wpse_checker (.*);

FILE: test/ws2812_slot_checker.sv
`timescale 1ns / 1ps
// Checker for the WS2812 slot encoder: follows all channels, predicts slots, compares them.
module ws2812_slot_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,
  input  logic                          m_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wpse_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wpse_pkg::CfgDataW-1:0] cfg_data,
  output int                            fail_count,
  output int                            slots_pending
);

  typedef struct packed {
    logic [wpse_pkg::DutyW-1:0] duty;
    logic                       last;
  } slot_t;

  // tan(angle) in Q1.16 for angles 0..45 degrees
  localparam logic [wpse_pkg::TanW-1:0] SlopeLut [46] = '{
    17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,  17'd6888,
    17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739, 17'd13930, 17'd15130,
    17'd16340, 17'd17560, 17'd18792, 17'd20036, 17'd21294, 17'd22566, 17'd23853,
    17'd25157, 17'd26478, 17'd27818, 17'd29179, 17'd30560, 17'd31964, 17'd33392,
    17'd34846, 17'd36327, 17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205,
    17'd45889, 17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
    17'd59009, 17'd61113, 17'd63287, 17'd65536
  };

  // Local copy of the slot settings
  logic [wpse_pkg::BrightW-1:0] angle;
  logic [wpse_pkg::DutyW-1:0]   mark_duty;
  logic [wpse_pkg::DutyW-1:0]   space_duty;
  logic [wpse_pkg::GapW-1:0]    gap_len;

  // Slots still owed by the block, oldest first
  slot_t owed_slots[$];

  // Scale one channel by tan(angle), truncating the fraction
  function automatic logic [wpse_pkg::ChanW-1:0] dim(input logic [wpse_pkg::ChanW-1:0] c,
                                                     input logic [wpse_pkg::BrightW-1:0] a);
    logic [24:0] prod;
    prod = c * SlopeLut[a];
    return prod[23:16];
  endfunction

  always @(posedge clk) begin : watch
    slot_t                      want;
    logic [wpse_pkg::WordW-1:0] grb;
    int                         k;
    if (rst) begin
      angle      = wpse_pkg::BrightReset;
      mark_duty  = wpse_pkg::DutyOneReset;
      space_duty = wpse_pkg::DutyZeroReset;
      gap_len    = wpse_pkg::GapReset;
      owed_slots.delete();
      fail_count = 0;
    end else begin
      // Compare each slot with the oldest one owed
      if (m_tvalid && m_tready) begin
        if (owed_slots.size() == 0) begin
          $display("%0t: unexpected slot: expected none, got duty %0d last %0d",
                   $time, m_tdata[5:0], m_tlast);
          fail_count++;
        end else begin
          want = owed_slots.pop_front();
          if (m_tdata[5:0] !== want.duty || m_tlast !== want.last) begin
            $display("%0t: slot differs: expected duty %0d last %0d, got duty %0d last %0d",
                     $time, want.duty, want.last, m_tdata[5:0], m_tlast);
            fail_count++;
          end
        end
      end

      // Expand each accepted item into its slots
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          for (k = 0; k < gap_len; k++) begin
            want.duty = '0;
            want.last = (k == gap_len - 1);
            owed_slots.push_back(want);
          end
        end else begin
          grb = {dim(s_tdata[15:8], angle), dim(s_tdata[7:0], angle),
                 dim(s_tdata[23:16], angle)};
          for (k = wpse_pkg::WordW - 1; k >= 0; k--) begin
            want.duty = grb[k] ? mark_duty : space_duty;
            want.last = (k == 0);
            owed_slots.push_back(want);
          end
        end
      end

      // Track register writes, with the block's clamping
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpse_pkg::RegBrightness:
            angle = (cfg_data[5:0] > wpse_pkg::BrightMax) ? wpse_pkg::BrightMax
                                                          : cfg_data[5:0];
          wpse_pkg::RegDutyOne:  mark_duty = cfg_data[5:0];
          wpse_pkg::RegDutyZero: space_duty = cfg_data[5:0];
          wpse_pkg::RegResetSlots:
            gap_len = (cfg_data < wpse_pkg::GapMin) ? wpse_pkg::GapMin :
                      (cfg_data > wpse_pkg::GapMax) ? wpse_pkg::GapMax : cfg_data;
          default: ;
        endcase
      end
    end
    slots_pending = owed_slots.size();
  end

endmodule

FILE: test/tb_ws2812_pwm_slot_encoder.sv
`timescale 1ns / 1ps
// Testbench top for the WS2812 slot encoder: stimulus, idle patterns, watchdog and verdict.
module tb_ws2812_pwm_slot_encoder;

  localparam logic ActPixel    = 1'b0;
  localparam logic ActFrameEnd = 1'b1;
  localparam int   QuietLimit  = 2000;
  localparam int   DrainCycles = 40;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [23:0]                   s_tdata;
  logic                          s_tuser;
  logic                          m_tvalid;
  logic                          m_tready = 1'b1;
  logic [7:0]                    m_tdata;
  logic                          m_tlast;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [wpse_pkg::CfgIdxW-1:0]  cfg_index;
  logic [wpse_pkg::CfgDataW-1:0] cfg_data;

  int fail_count;
  int slots_pending;
  int send_idle_pct;
  int rdy_stall_pct;
  int quiet_cycles;

  ws2812_pwm_slot_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ws2812_slot_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .slots_pending (slots_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the slot output at random
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= rdy_stall_pct);
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("ws2812_pwm_slot_encoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drop valid and hold until every owed slot has come out
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (slots_pending != 0) @(negedge clk);
  endtask

  // Offer one item, with random gaps before it
  task automatic put_item(input logic act, input logic [7:0] red, input logic [7:0] green,
                          input logic [7:0] blue);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {blue, green, red};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Write one register once the block is idle
  task automatic write_reg(input logic [wpse_pkg::CfgIdxW-1:0] idx,
                           input logic [wpse_pkg::CfgDataW-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Channel value biased toward the extremes
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random settings, mostly short latch gaps, now and then an unknown index
  task automatic shuffle_regs();
    write_reg(wpse_pkg::RegBrightness, ($urandom_range(0, 3) == 0) ? 7'($urandom_range(46, 127))
                                                                   : 7'($urandom_range(0, 45)));
    write_reg(wpse_pkg::RegDutyOne, 7'($urandom_range(0, 127)));
    write_reg(wpse_pkg::RegDutyZero, 7'($urandom_range(0, 127)));
    write_reg(wpse_pkg::RegResetSlots, ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                                   : 7'($urandom_range(1, 10)));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(wpse_pkg::CfgIdxW'($urandom_range(4, 7)), 7'($urandom_range(0, 127)));
    end
  endtask

  // One random phase under a given idle pattern
  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int i;
    shuffle_regs();
    send_idle_pct = idle_pct;
    rdy_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      // hold the sender once until the output has drained
      if (i == count / 2) wait_drained();
      put_item(($urandom_range(0, 6) == 0) ? ActFrameEnd : ActPixel,
               pick_chan(), pick_chan(), pick_chan());
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tuser       = ActPixel;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    rdy_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Reset settings: extremes and bit patterns, frame end with colors set
    put_item(ActPixel, 8'h00, 8'h00, 8'h00);
    put_item(ActPixel, 8'hFF, 8'hFF, 8'hFF);
    put_item(ActPixel, 8'hAA, 8'h55, 8'hA5);
    put_item(ActFrameEnd, 8'hFF, 8'hFF, 8'hFF);

    // Brightness above range saturates to full scale
    write_reg(wpse_pkg::RegBrightness, 7'h7F);
    put_item(ActPixel, 8'hFF, 8'hFF, 8'hFF);
    put_item(ActPixel, 8'h80, 8'h01, 8'h7E);

    // Widest duty spread, shortest latch gap from a zero write
    write_reg(wpse_pkg::RegDutyOne, 7'h3F);
    write_reg(wpse_pkg::RegDutyZero, 7'h00);
    write_reg(wpse_pkg::RegResetSlots, 7'h00);
    put_item(ActPixel, 8'hF0, 8'h0F, 8'h3C);
    put_item(ActFrameEnd, 8'h00, 8'h00, 8'h00);

    // Longest latch gap, from an oversized write and an exact one
    write_reg(wpse_pkg::RegResetSlots, 7'h7F);
    put_item(ActFrameEnd, 8'h12, 8'h34, 8'h56);
    write_reg(wpse_pkg::RegResetSlots, 7'd64);
    write_reg(3'd4, 7'h7F);
    write_reg(3'd5, 7'h00);
    write_reg(3'd6, 7'h7F);
    write_reg(3'd7, 7'h55);
    put_item(ActFrameEnd, 8'h00, 8'h00, 8'h00);

    // Zero brightness and inverted duties
    write_reg(wpse_pkg::RegBrightness, 7'h00);
    put_item(ActPixel, 8'hFF, 8'hFF, 8'hFF);
    write_reg(wpse_pkg::RegDutyOne, 7'h00);
    write_reg(wpse_pkg::RegDutyZero, 7'h7F);
    put_item(ActPixel, 8'hFF, 8'h00, 8'h00);

    // Smallest nonzero and highest angles below full scale
    write_reg(wpse_pkg::RegBrightness, 7'd1);
    put_item(ActPixel, 8'hFF, 8'hFF, 8'hFF);
    write_reg(wpse_pkg::RegBrightness, 7'd44);
    put_item(ActPixel, 8'hFF, 8'h80, 8'h01);

    // Back-to-back frame ends around a pixel
    write_reg(wpse_pkg::RegResetSlots, 7'd2);
    put_item(ActFrameEnd, 8'h00, 8'h00, 8'h00);
    put_item(ActPixel, 8'h01, 8'hFE, 8'h7F);
    put_item(ActFrameEnd, 8'hFF, 8'h00, 8'hFF);

    write_reg(wpse_pkg::RegBrightness, 7'd45);
    write_reg(wpse_pkg::RegDutyOne, 7'd1);
    write_reg(wpse_pkg::RegDutyZero, 7'd62);
    put_item(ActPixel, 8'h55, 8'hAA, 8'h5A);

    // Random phases under each idle pattern
    run_phase(0, 0, 38);
    run_phase(55, 0, 38);
    run_phase(0, 55, 38);
    run_phase(7, 7, 38);

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && slots_pending == 0) begin
      $display("ws2812_pwm_slot_encoder: match");
    end else begin
      $display("ws2812_pwm_slot_encoder: mismatch");
    end
    $finish;
  end

endmodule
